FILE: sv/gregorian_date_offset_top_macros.svh
// ----------------------------------------------------------------------------
// Gregorian date offset: assertion macros
// Shared concurrent assertion forms for the date offset RTL.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_OFFSET_TOP_MACROS_SVH
`define GREGORIAN_DATE_OFFSET_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off in reset
`define GDO_ASSERT_IMPL(name, ck, rstn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("gregorian_date_offset: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off in reset
`define GDO_ASSERT_NEXT(name, ck, rstn, ante, cons) \
  name: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("gregorian_date_offset: next-cycle check failed");

`endif

FILE: sv/gdo_pkg.sv
// ----------------------------------------------------------------------------
// Gregorian date offset package
// Types, calendar constants, sequencer states and the month length table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gdo_pkg;

  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 14;
  localparam int OFF_W  = 16;
  // Day accumulator: holds day + offset or day - offset, signed
  localparam int ACC_W  = 18;

  typedef logic [DAY_W-1:0]         day_t;
  typedef logic [MON_W-1:0]         month_t;
  typedef logic [YEAR_W-1:0]        year_t;
  typedef logic [OFF_W-1:0]         off_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  localparam year_t  YEAR_MIN = 14'd1;
  localparam year_t  YEAR_MAX = 14'd9999;
  localparam year_t  CENTURY  = 14'd100;
  localparam year_t  REM_TOP  = 14'd99;
  localparam month_t MON_JAN  = 4'd1;
  localparam month_t MON_FEB  = 4'd2;
  localparam month_t MON_APR  = 4'd4;
  localparam month_t MON_JUN  = 4'd6;
  localparam month_t MON_SEP  = 4'd9;
  localparam month_t MON_NOV  = 4'd11;
  localparam month_t MON_DEC  = 4'd12;
  localparam day_t   DAY_FIRST = 5'd1;
  localparam day_t   DAY_28   = 5'd28;
  localparam day_t   DAY_29   = 5'd29;
  localparam day_t   DAY_30   = 5'd30;
  localparam day_t   DAY_31   = 5'd31;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENT,
    ST_CLAMP,
    ST_OFFS,
    ST_WALK,
    ST_DONE
  } state_t;

  // Operations of the shared adder
  typedef enum logic [1:0] {
    OP_CENT,
    OP_OFFS,
    OP_FWD,
    OP_BACK
  } alu_op_t;

  // Request to the shared adder and calendar unit
  typedef struct packed {
    alu_op_t op;
    logic    subtract;
    acc_t    acc;
    year_t   rem;
    off_t    off;
    month_t  month;
    logic [1:0] year_lo;
    logic [1:0] cen;
  } alu_req_t;

  // Answer of the shared adder and calendar unit
  typedef struct packed {
    acc_t sum;
    day_t mlen;
    day_t mlen_prev;
  } alu_rsp_t;

  // Days in a month, leap flag for February
  function automatic day_t month_len(input month_t m, input logic leap);
    day_t len;
    case (m)
      MON_FEB: len = leap ? DAY_29 : DAY_28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = DAY_30;
      default: len = DAY_31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: sv/gdo_alu.sv
// ----------------------------------------------------------------------------
// Gregorian date offset: shared adder and calendar unit
// One signed adder serves the century reduction, the offset apply and the
// month steps; also derives the leap flag and the month lengths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gdo_alu (
  input  wire gdo_pkg::alu_req_t req,
  output gdo_pkg::alu_rsp_t      rsp
);

  logic          leap;
  gdo_pkg::day_t mlen;
  gdo_pkg::day_t mlen_prev;
  gdo_pkg::acc_t opa;
  gdo_pkg::acc_t opb;

  // Leap: year%4==0 and year%100!=0, or year%400==0 (rem = year%100,
  // cen = (year/100)%4)
  assign leap = ((req.year_lo == 2'b00) && (req.rem != '0)) ||
                ((req.rem == '0) && (req.cen == 2'b00));

  // Month lengths of the current and the preceding month
  always_comb begin
    mlen = gdo_pkg::month_len(req.month, leap);
    if (req.month == gdo_pkg::MON_JAN) begin
      mlen_prev = gdo_pkg::DAY_31;
    end else begin
      mlen_prev = gdo_pkg::month_len(req.month - gdo_pkg::MON_JAN, leap);
    end
  end

  // Select adder operands
  always_comb begin
    case (req.op)
      gdo_pkg::OP_CENT: begin
        opa = gdo_pkg::acc_t'({4'b0000, req.rem});
        opb = gdo_pkg::acc_t'(0) - gdo_pkg::acc_t'({4'b0000, gdo_pkg::CENTURY});
      end
      gdo_pkg::OP_OFFS: begin
        opa = req.acc;
        if (req.subtract) begin
          opb = gdo_pkg::acc_t'(0) - gdo_pkg::acc_t'({2'b00, req.off});
        end else begin
          opb = gdo_pkg::acc_t'({2'b00, req.off});
        end
      end
      gdo_pkg::OP_FWD: begin
        opa = req.acc;
        opb = gdo_pkg::acc_t'(0) - gdo_pkg::acc_t'({13'b0, mlen});
      end
      gdo_pkg::OP_BACK: begin
        opa = req.acc;
        opb = gdo_pkg::acc_t'({13'b0, mlen_prev});
      end
      default: begin
        opa = req.acc;
        opb = '0;
      end
    endcase
  end

  assign rsp.sum       = opa + opb;
  assign rsp.mlen      = mlen;
  assign rsp.mlen_prev = mlen_prev;

endmodule

`default_nettype wire

FILE: sv/gregorian_date_offset_top.sv
// ----------------------------------------------------------------------------
// Gregorian date offset: top level
// Moves a Gregorian date forward or back by a day count, one month a cycle.
// ----------------------------------------------------------------------------
// One date is worked at a time; in_tready is high only while the sequencer is
// idle. Each accepted date passes through the states CENT, CLAMP, OFFS, WALK
// and DONE in that order before the sequencer is idle again. CENT is the
// century reduction that sets up the leap counters by repeated subtraction of
// 100, once for each of the year/100 (at most 99) centuries, and WALK steps
// the months, one a cycle through the shared adder (up to about 2155 for the
// largest offset). The result sits in an output register, so the next
// date is taken while it waits; a result that is still waiting when the next
// walk ends holds the sequencer until the output slot frees.
`timescale 1ns / 1ps
`default_nettype none

`include "gregorian_date_offset_top_macros.svh"

module gregorian_date_offset_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input beat
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // day_in[4:0], month_in[8:5], year_in[22:9], offset_days[38:23], pad[39]
  input  wire logic [39:0] in_tdata,
  // action[0]
  input  wire logic [0:0]  in_tuser,
  // Result beat
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // day_out[4:0], month_out[8:5], year_out[22:9], pad[23]
  output logic [23:0]      out_tdata,
  // out_of_range[0]
  output logic [0:0]       out_tuser
);

  gdo_pkg::state_t   state_r, state_nxt;
  gdo_pkg::alu_op_t  alu_op;
  gdo_pkg::alu_req_t req;
  gdo_pkg::alu_rsp_t rsp;

  logic            sub_r, sub_nxt;
  logic            flag_r, flag_nxt;
  gdo_pkg::acc_t   acc_r, acc_nxt;
  gdo_pkg::month_t month_r, month_nxt;
  gdo_pkg::year_t  year_r, year_nxt;
  gdo_pkg::year_t  rem_r, rem_nxt;
  logic [1:0]      cen_r, cen_nxt;
  gdo_pkg::off_t   off_r, off_nxt;

  logic            out_valid_r, out_valid_nxt;
  gdo_pkg::day_t   out_day_r, out_day_nxt;
  gdo_pkg::month_t out_month_r, out_month_nxt;
  gdo_pkg::year_t  out_year_r, out_year_nxt;
  logic            out_flag_r, out_flag_nxt;

  logic            in_fire;
  logic            out_free;
  logic            walk_more;
  logic            walk_sat;

  logic            in_walk;
  logic            in_done;
  logic            month_ok;
  logic            at_first_date;
  logic            at_last_date;

  gdo_pkg::day_t   day_in;
  gdo_pkg::month_t month_in;
  gdo_pkg::year_t  year_in;

  assign day_in   = in_tdata[4:0];
  assign month_in = in_tdata[8:5];
  assign year_in  = in_tdata[22:9];

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // Shared adder request
  assign req.op       = alu_op;
  assign req.subtract = sub_r;
  assign req.acc      = acc_r;
  assign req.rem      = rem_r;
  assign req.off      = off_r;
  assign req.month    = month_r;
  assign req.year_lo  = year_r[1:0];
  assign req.cen      = cen_r;

  gdo_alu u_alu (
    .req (req),
    .rsp (rsp)
  );

  // Walk status: another month to step, or the year ran off the range
  always_comb begin
    if (!sub_r) begin
      walk_more = !rsp.sum[gdo_pkg::ACC_W-1] && (rsp.sum != '0);
      walk_sat  = walk_more && (month_r == gdo_pkg::MON_DEC) &&
                  (year_r == gdo_pkg::YEAR_MAX);
    end else begin
      walk_more = (acc_r < gdo_pkg::acc_t'(1));
      walk_sat  = walk_more && (month_r == gdo_pkg::MON_JAN) &&
                  (year_r == gdo_pkg::YEAR_MIN);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gdo_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = gdo_pkg::ST_CENT;
        end
      end
      gdo_pkg::ST_CENT: begin
        if (rsp.sum[gdo_pkg::ACC_W-1]) begin
          state_nxt = gdo_pkg::ST_CLAMP;
        end
      end
      gdo_pkg::ST_CLAMP: state_nxt = gdo_pkg::ST_OFFS;
      gdo_pkg::ST_OFFS:  state_nxt = gdo_pkg::ST_WALK;
      gdo_pkg::ST_WALK: begin
        if (!walk_more || walk_sat) begin
          state_nxt = gdo_pkg::ST_DONE;
        end
      end
      gdo_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = gdo_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gdo_pkg::ST_IDLE;
    endcase
  end

  // State outputs: handshake and adder operation
  always_comb begin
    in_tready = 1'b0;
    alu_op    = gdo_pkg::OP_CENT;
    case (state_r)
      gdo_pkg::ST_IDLE: in_tready = 1'b1;
      gdo_pkg::ST_CENT: alu_op = gdo_pkg::OP_CENT;
      gdo_pkg::ST_OFFS: alu_op = gdo_pkg::OP_OFFS;
      gdo_pkg::ST_WALK: alu_op = sub_r ? gdo_pkg::OP_BACK : gdo_pkg::OP_FWD;
      default:          alu_op = gdo_pkg::OP_CENT;
    endcase
  end

  // Working registers: load, reduce century, clamp, apply offset, walk
  always_comb begin
    sub_nxt   = sub_r;
    flag_nxt  = flag_r;
    acc_nxt   = acc_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    rem_nxt   = rem_r;
    cen_nxt   = cen_r;
    off_nxt   = off_r;
    case (state_r)
      gdo_pkg::ST_IDLE: begin
        if (in_fire) begin
          sub_nxt  = in_tuser[0];
          flag_nxt = 1'b0;
          acc_nxt  = gdo_pkg::acc_t'({13'b0, day_in});
          off_nxt  = in_tdata[38:23];
          cen_nxt  = 2'b00;
          if (month_in == '0) begin
            month_nxt = gdo_pkg::MON_JAN;
          end else if (month_in > gdo_pkg::MON_DEC) begin
            month_nxt = gdo_pkg::MON_DEC;
          end else begin
            month_nxt = month_in;
          end
          if (year_in == '0) begin
            year_nxt = gdo_pkg::YEAR_MIN;
          end else if (year_in > gdo_pkg::YEAR_MAX) begin
            year_nxt = gdo_pkg::YEAR_MAX;
          end else begin
            year_nxt = year_in;
          end
          rem_nxt = year_nxt;
        end
      end
      gdo_pkg::ST_CENT: begin
        if (!rsp.sum[gdo_pkg::ACC_W-1]) begin
          rem_nxt = rsp.sum[gdo_pkg::YEAR_W-1:0];
          cen_nxt = cen_r + 2'd1;
        end
      end
      gdo_pkg::ST_CLAMP: begin
        if (acc_r[gdo_pkg::DAY_W-1:0] == '0) begin
          acc_nxt = gdo_pkg::acc_t'(1);
        end else if (acc_r[gdo_pkg::DAY_W-1:0] > rsp.mlen) begin
          acc_nxt = gdo_pkg::acc_t'({13'b0, rsp.mlen});
        end
      end
      gdo_pkg::ST_OFFS: acc_nxt = rsp.sum;
      gdo_pkg::ST_WALK: begin
        if (walk_sat) begin
          // Year left the range: saturate to the nearest end
          flag_nxt = 1'b1;
          if (sub_r) begin
            acc_nxt   = gdo_pkg::acc_t'(1);
            month_nxt = gdo_pkg::MON_JAN;
            year_nxt  = gdo_pkg::YEAR_MIN;
          end else begin
            acc_nxt   = gdo_pkg::acc_t'({13'b0, gdo_pkg::DAY_31});
            month_nxt = gdo_pkg::MON_DEC;
            year_nxt  = gdo_pkg::YEAR_MAX;
          end
        end else if (walk_more) begin
          acc_nxt = rsp.sum;
          if (!sub_r) begin
            if (month_r == gdo_pkg::MON_DEC) begin
              month_nxt = gdo_pkg::MON_JAN;
              year_nxt  = year_r + 14'd1;
              if (rem_r == gdo_pkg::REM_TOP) begin
                rem_nxt = '0;
                cen_nxt = cen_r + 2'd1;
              end else begin
                rem_nxt = rem_r + 14'd1;
              end
            end else begin
              month_nxt = month_r + 4'd1;
            end
          end else begin
            if (month_r == gdo_pkg::MON_JAN) begin
              month_nxt = gdo_pkg::MON_DEC;
              year_nxt  = year_r - 14'd1;
              if (rem_r == '0) begin
                rem_nxt = gdo_pkg::REM_TOP;
                cen_nxt = cen_r - 2'd1;
              end else begin
                rem_nxt = rem_r - 14'd1;
              end
            end else begin
              month_nxt = month_r - 4'd1;
            end
          end
        end
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  // Output register: load when the walk is done and the slot frees
  always_comb begin
    out_day_nxt   = out_day_r;
    out_month_nxt = out_month_r;
    out_year_nxt  = out_year_r;
    out_flag_nxt  = out_flag_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if ((state_r == gdo_pkg::ST_DONE) && out_free) begin
      out_valid_nxt = 1'b1;
      out_day_nxt   = acc_r[gdo_pkg::DAY_W-1:0];
      out_month_nxt = month_r;
      out_year_nxt  = year_r;
      out_flag_nxt  = flag_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gdo_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sub_r       <= sub_nxt;
    flag_r      <= flag_nxt;
    acc_r       <= acc_nxt;
    month_r     <= month_nxt;
    year_r      <= year_nxt;
    rem_r       <= rem_nxt;
    cen_r       <= cen_nxt;
    off_r       <= off_nxt;
    out_day_r   <= out_day_nxt;
    out_month_r <= out_month_nxt;
    out_year_r  <= out_year_nxt;
    out_flag_r  <= out_flag_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_year_r, out_month_r, out_day_r};
  assign out_tuser  = out_flag_r;

  // Terms for the checks below
  assign in_walk       = (state_r == gdo_pkg::ST_WALK);
  assign in_done       = (state_r == gdo_pkg::ST_DONE);
  assign month_ok      = (month_r >= gdo_pkg::MON_JAN) && (month_r <= gdo_pkg::MON_DEC);
  assign at_first_date = (out_year_r == gdo_pkg::YEAR_MIN) &&
                         (out_month_r == gdo_pkg::MON_JAN) &&
                         (out_day_r == gdo_pkg::DAY_FIRST);
  assign at_last_date  = (out_year_r == gdo_pkg::YEAR_MAX) &&
                         (out_month_r == gdo_pkg::MON_DEC) &&
                         (out_day_r == gdo_pkg::DAY_31);

  // Century remainder stays reduced while months are walked
  `GDO_ASSERT_IMPL(a_rem_reduced, clk, rst_n, in_walk, rem_r < gdo_pkg::CENTURY)

  // Month stays a calendar month during the walk
  `GDO_ASSERT_IMPL(a_month_valid, clk, rst_n, in_walk, month_ok)

  // A range flag comes only with a saturated date at one end
  `GDO_ASSERT_IMPL(a_flag_sat, clk, rst_n, out_valid_r && out_flag_r, at_first_date || at_last_date)

  // A finished date with a free slot shows up as a result beat, with the sequencer idle again
  `GDO_ASSERT_NEXT(a_done_loads, clk, rst_n, in_done && out_free, out_valid_r && in_tready)

endmodule

`default_nettype wire
